>>> sv/pxadj_pkg.sv
package pxadj_pkg;

  localparam int MaxWidth   = 64;
  localparam int AddrW      = $clog2(MaxWidth);
  localparam int ColW       = AddrW + 1;
  localparam int HeightMax  = 4096;
  localparam int RowW       = $clog2(HeightMax);
  localparam int HeightW    = RowW + 1;
  localparam int CfgDataW   = HeightW;

  localparam logic [0:0] CfgImageWidth  = 1'b0;
  localparam logic [0:0] CfgImageHeight = 1'b1;

  localparam logic [ColW-1:0]    WidthReset  = ColW'(MaxWidth);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(1);

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       row_end;
    logic       frame_end;
  } pix_out_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic issue;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_done;
    logic rd_last;
    logic rd_free;
  } dp_status_t;

endpackage

>>> sv/pxadj_ctrl.sv
module pxadj_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pxadj_pkg::dp_status_t status_i,
  output pxadj_pkg::ctrl_cmd_t  cmd_o
);
  import pxadj_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.issue  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.row_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // read the row back, highest column first
        cmd_o.issue = status_i.rd_free;
        if (status_i.rd_free && status_i.rd_last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

>>> sv/pxadj_dp.sv
module pxadj_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_idx_i,
  input  logic [pxadj_pkg::CfgDataW-1:0]      cfg_data_i,
  input  pxadj_pkg::pix_in_t                  in_data_i,
  output pxadj_pkg::pix_out_t                 out_data_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  pxadj_pkg::ctrl_cmd_t                cmd_i,
  output pxadj_pkg::dp_status_t               status_o
);
  import pxadj_pkg::*;

  logic [ColW-1:0]    width_q;
  logic [HeightW-1:0] height_q;
  logic [ColW-1:0]    eff_w;
  logic [HeightW-1:0] eff_h;

  logic [AddrW-1:0]   col_q;
  logic [3:0]         cm9_q;
  logic [RowW-1:0]    row_q;
  logic [2:0]         rm7_q;
  logic               last_row_q;

  logic [ColW-1:0]    col_inc;
  logic [HeightW-1:0] row_inc;
  logic               row_done;
  logic               last_row;

  logic [8:0]         red_sum;
  logic [7:0]         red_adj;
  logic [7:0]         blue_adj;

  logic [23:0]        mem [MaxWidth];
  logic [AddrW-1:0]   rd_addr_q;
  logic [23:0]        rd_data_q;
  logic               rd_v_q;
  logic               rd_row_end_q;
  logic               rd_frame_end_q;
  logic               move;
  pix_out_t           out_q;
  logic               out_v_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgImageWidth:  width_q  <= cfg_data_i[ColW-1:0];
        CfgImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = width_q;
    if (width_q == '0) eff_w = ColW'(1);
    else if (width_q > ColW'(MaxWidth)) eff_w = ColW'(MaxWidth);
    eff_h = height_q;
    if (height_q == '0) eff_h = HeightW'(1);
    else if (height_q > HeightW'(HeightMax)) eff_h = HeightW'(HeightMax);
  end

  assign col_inc  = {1'b0, col_q} + ColW'(1);
  assign row_inc  = {1'b0, row_q} + HeightW'(1);
  assign row_done = (col_inc >= eff_w);
  assign last_row = (row_inc >= eff_h);

  // pixel adjust: saturating red, floored blue
  assign red_sum  = {1'b0, in_data_i.red_in} + {5'b0, cm9_q};
  assign red_adj  = red_sum[8] ? 8'hFF : red_sum[7:0];
  assign blue_adj = (in_data_i.blue_in >= {5'b0, rm7_q}) ?
                    (in_data_i.blue_in - {5'b0, rm7_q}) : 8'h00;

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      cm9_q      <= '0;
      row_q      <= '0;
      rm7_q      <= '0;
      last_row_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (!row_done) begin
          col_q <= col_inc[AddrW-1:0];
          cm9_q <= (cm9_q >= 4'd8) ? 4'd0 : cm9_q + 4'd1;
        end else begin
          col_q      <= '0;
          cm9_q      <= '0;
          rd_addr_q  <= col_q;
          last_row_q <= last_row;
          if (last_row) begin
            row_q <= '0;
            rm7_q <= '0;
          end else begin
            row_q <= row_inc[RowW-1:0];
            rm7_q <= (rm7_q >= 3'd6) ? 3'd0 : rm7_q + 3'd1;
          end
        end
      end else if (cmd_i.issue) begin
        rd_addr_q <= rd_addr_q - AddrW'(1);
      end
    end
  end

  // row buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[col_q] <= {red_adj, in_data_i.green_in, blue_adj};
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  // read stage then output register
  assign move = rd_v_q && (!out_v_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.issue || (rd_v_q && !move);
      out_v_q <= move || (out_v_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_row_end_q   <= (rd_addr_q == '0);
      rd_frame_end_q <= (rd_addr_q == '0) && last_row_q;
    end
    if (move) begin
      out_q.red_out   <= rd_data_q[23:16];
      out_q.green_out <= rd_data_q[15:8];
      out_q.blue_out  <= rd_data_q[7:0];
      out_q.row_end   <= rd_row_end_q;
      out_q.frame_end <= rd_frame_end_q;
    end
  end

  assign out_data_o        = out_q;
  assign out_valid_o       = out_v_q;
  assign status_o.row_done = row_done;
  assign status_o.rd_last  = (rd_addr_q == '0);
  assign status_o.rd_free  = !rd_v_q || move;

endmodule

>>> sv/pixel_adjust_and_row_mirror.sv
// A row of W words loads at one word per cycle while in_valid_i is high; after its last input
// word, the W words read back out of the single-port row buffer at one word per cycle unless the
// output stalls, passing through the read stage and then the output register.
// Input is held off while a row is being read back; output stalls back up into the read.
// Reset: counters zero, width 64, height 1, pipeline empty; the row buffer is not cleared.
module pixel_adjust_and_row_mirror (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [pxadj_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pxadj_pkg::pix_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pxadj_pkg::pix_out_t             out_data_o
);
  import pxadj_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pxadj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pxadj_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
